// ===== rtl/tds_pkg.sv =====
// Shared constants, types and fixed-point helpers for the tridiagonal solver.
package tds_pkg;

  localparam int MaxRows = 32;
  localparam int AddrW   = $clog2(MaxRows);
  localparam int CountW  = $clog2(MaxRows + 1);
  localparam int DataW   = 32;
  localparam int IdxW    = 6;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_ZERO_PIVOT = 2'd1,
    STAT_OVERFLOW   = 2'd2
  } status_t;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) sat34 = 32'sh7FFF_FFFF;
    else if (v < lo) sat34 = 32'sh8000_0000;
    else sat34 = v[31:0];
  endfunction

  // Q16.16 product from a registered 64-bit raw product, truncated toward zero.
  function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
    logic [63:0] mag;
    logic [47:0] sh;
    logic signed [49:0] r;
    mag = p[63] ? 64'(-p) : 64'(p);
    sh  = mag[63:16];
    r   = p[63] ? -$signed({2'b00, sh}) : $signed({2'b00, sh});
    if (r > 50'sh7FFF_FFFF) qscale = 32'sh7FFF_FFFF;
    else if (r < -50'sh8000_0000) qscale = 32'sh8000_0000;
    else qscale = r[31:0];
  endfunction

endpackage

// ===== rtl/tds_if.sv =====
// Valid/ready channel interfaces for rows and solution components.
interface tds_row_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sub_diag;
  logic signed [31:0] main_diag;
  logic signed [31:0] super_diag;
  logic signed [31:0] rhs;
  logic               last_row;
  modport source (output valid, sub_diag, main_diag, super_diag, rhs, last_row, input ready);
  modport sink   (input valid, sub_diag, main_diag, super_diag, rhs, last_row, output ready);
endinterface

interface tds_sol_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] solution;
  logic [5:0]         row_index;
  logic               last_result;
  logic [1:0]         status;
  modport source (output valid, solution, row_index, last_result, status, input ready);
  modport sink   (input valid, solution, row_index, last_result, status, output ready);
endinterface

// ===== rtl/tridiagonal_system_solver.sv =====
// Top level: Thomas-algorithm tridiagonal solver over alpha/beta memories.
//
// Usage: rows arrive on the in_ channel, one transaction per matrix row,
// the final row flagged by last_row. For each row, two
// Q16.16 quotients (alpha, beta) run one after the other through a shared
// bit-serial divider of 48 steps each, plus memory reads and products.
// alpha and beta live in two 32-entry RAMs with registered reads.
// After the last row, back substitution reads the memories from the top
// index down and delivers one solution transaction per stored row on the
// out_ channel; last_result marks index 0 and status carries the
// system's error code.
// The block takes one item at a time: in_ready is low from acceptance until
// a row is stored, and during the whole output run. When the receiver holds
// out_ready low the current solution waits in the output register and the
// sweep pauses. Reset (rst_n low, synchronous) clears the row count, error
// code and control; the memories need no clearing since only entries
// written in the current system are read.
module tridiagonal_system_solver (
  input  logic clk,
  input  logic rst_n,
  tds_row_if.sink   in_,
  tds_sol_if.source out_
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_MUL, S_PIV, S_DIVA, S_DIVB, S_BS_RD, S_BS_MUL, S_BS_OUT
  } state_t;

  state_t state_r;
  logic [tds_pkg::CountW-1:0] cnt_r;
  logic [1:0]  err_r;
  logic signed [31:0] sub_r, dia_r, sup_r, rhs_r;
  logic        last_r;
  logic signed [63:0] pa_r, pb_r;
  logic signed [31:0] y_r, bnum_r, alpha_r;
  logic        zpiv_r;
  logic        dstart_r;
  logic signed [32:0] dnum_r;
  logic [tds_pkg::AddrW-1:0] idx_r;
  logic signed [31:0] x_r;
  logic        first_r;
  logic        ovalid_r;
  logic signed [31:0] osol_r;
  logic [tds_pkg::IdxW-1:0] oidx_r;
  logic        olast_r;
  logic [1:0]  ostat_r;

  logic        we;
  logic [tds_pkg::AddrW-1:0] waddr, raddr;
  logic [31:0] a_wdata, b_wdata, a_rdata, b_rdata;
  logic        ddone;
  logic signed [31:0] dq;
  logic        ofire;

  // memory ports
  always_comb begin
    raddr = idx_r;
    waddr = cnt_r[tds_pkg::AddrW-1:0];
  end

  tds_ram #(.Width(tds_pkg::DataW), .Depth(tds_pkg::MaxRows)) u_alpha (
    .clk, .we, .waddr, .wdata(a_wdata), .raddr, .rdata(a_rdata));
  tds_ram #(.Width(tds_pkg::DataW), .Depth(tds_pkg::MaxRows)) u_beta (
    .clk, .we, .waddr, .wdata(b_wdata), .raddr, .rdata(b_rdata));

  tds_div u_div (.clk, .rst_n, .start(dstart_r), .num(dnum_r), .den(y_r),
    .done(ddone), .quot(dq));

  assign we      = (state_r == S_DIVB) && ddone;
  assign a_wdata = alpha_r;
  assign b_wdata = dq;

  // a solution is loaded into the output register
  assign ofire = (state_r == S_BS_OUT) && (!ovalid_r || out_.ready);

  assign in_.ready        = (state_r == S_IDLE);
  assign out_.valid       = ovalid_r;
  assign out_.solution    = osol_r;
  assign out_.row_index   = oidx_r;
  assign out_.last_result = olast_r;
  assign out_.status      = ostat_r;

  // sequencer: forward sweep, then back substitution
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      err_r    <= tds_pkg::STAT_OK;
      ovalid_r <= 1'b0;
      dstart_r <= 1'b0;
    end else begin
      ovalid_r <= ofire || (ovalid_r && !out_.ready);
      dstart_r <= (state_r == S_DIVA) && (first_r || ddone);
      unique case (state_r)
        S_IDLE: begin
          if (in_.valid) begin
            sub_r  <= in_.sub_diag;
            dia_r  <= in_.main_diag;
            sup_r  <= in_.last_row ? 32'sd0 : in_.super_diag;
            rhs_r  <= in_.rhs;
            last_r <= in_.last_row;
            idx_r  <= cnt_r[tds_pkg::AddrW-1:0] - tds_pkg::AddrW'(1);
            if (cnt_r == tds_pkg::CountW'(tds_pkg::MaxRows)) begin
              if (err_r == tds_pkg::STAT_OK) err_r <= tds_pkg::STAT_OVERFLOW;
              if (in_.last_row) begin
                first_r <= 1'b1;
                state_r <= S_BS_RD;
              end
            end else begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: state_r <= S_MUL;  // read data of previous row arrives
        S_MUL: begin
          pa_r    <= 64'(sub_r) * 64'(signed'(a_rdata));
          pb_r    <= 64'(sub_r) * 64'(signed'(b_rdata));
          state_r <= S_PIV;
        end
        S_PIV: begin
          if (cnt_r == '0) begin
            y_r    <= dia_r;
            bnum_r <= rhs_r;
          end else begin
            y_r    <= tds_pkg::sat34(34'(dia_r) + 34'(tds_pkg::qscale(pa_r)));
            bnum_r <= tds_pkg::sat34(34'(rhs_r) - 34'(tds_pkg::qscale(pb_r)));
          end
          state_r <= S_DIVA;
          first_r <= 1'b1;
        end
        S_DIVA: begin
          if (first_r) begin
            first_r <= 1'b0;
            zpiv_r  <= (y_r == '0);
            if (y_r == '0) begin
              // zero pivot: store zeros and flag the system
              dnum_r <= '0;
              y_r    <= 32'sd1;
              if (err_r == tds_pkg::STAT_OK) err_r <= tds_pkg::STAT_ZERO_PIVOT;
            end else begin
              dnum_r <= -33'(sup_r);
            end
          end else if (ddone) begin
            alpha_r <= dq;
            dnum_r  <= zpiv_r ? 33'sd0 : 33'(bnum_r);
            state_r <= S_DIVB;
          end
        end
        S_DIVB: begin
          if (ddone) begin
            cnt_r <= cnt_r + tds_pkg::CountW'(1);
            if (last_r) begin
              idx_r   <= cnt_r[tds_pkg::AddrW-1:0];
              first_r <= 1'b1;
              state_r <= S_BS_RD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        S_BS_RD: state_r <= S_BS_MUL;
        S_BS_MUL: begin
          pa_r    <= 64'(signed'(a_rdata)) * 64'(x_r);
          bnum_r  <= b_rdata;
          state_r <= S_BS_OUT;
        end
        S_BS_OUT: begin
          if (ofire) begin
            x_r <= first_r ? bnum_r
                 : tds_pkg::sat34(34'(tds_pkg::qscale(pa_r)) + 34'(bnum_r));
            osol_r   <= first_r ? bnum_r
                 : tds_pkg::sat34(34'(tds_pkg::qscale(pa_r)) + 34'(bnum_r));
            oidx_r   <= tds_pkg::IdxW'(idx_r);
            olast_r  <= (idx_r == '0);
            ostat_r  <= err_r;
            first_r  <= 1'b0;
            if (idx_r == '0) begin
              cnt_r   <= '0;
              err_r   <= tds_pkg::STAT_OK;
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r - tds_pkg::AddrW'(1);
              state_r <= S_BS_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/tds_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
module tds_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/tds_div.sv =====
// Restoring divider: signed Q16.16 quotient (n << 16) / d, saturated, one bit a cycle.
module tds_div (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  // magnitude of num << 16 fits in 49 bits; its top bit is preloaded in rem
  logic [47:0] dvd_r, dvd_nxt;
  logic [47:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dsr_r, dsr_nxt;
  logic        neg_r, neg_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [32:0] num_mag;
  logic [32:0] trial;
  logic signed [49:0] sq;

  assign num_mag = num[32] ? 33'(-num) : 33'(num);
  assign trial   = {rem_r[31:0], dvd_r[47]};

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = {num_mag[31:0], 16'd0};
      rem_nxt  = {32'd0, num_mag[32]};
      dsr_nxt  = den[31] ? 33'(-$signed({den[31], den})) : {1'b0, den};
      neg_nxt  = num[32] ^ den[31];
      q_nxt    = '0;
      cnt_nxt  = 6'd48;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // num_mag bit 32 is preloaded in rem; 48 shifts cover bits 47..0
      if (trial >= dsr_r) begin
        rem_nxt = trial - dsr_r;
        q_nxt   = {q_r[46:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[46:0], 1'b0};
      end
      dvd_nxt = {dvd_r[46:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    neg_r <= neg_nxt;
  end

  // the magnitude bit 32 of num enters rem first, so the quotient holds 48 bits
  assign sq = neg_r ? -$signed({2'b00, q_r}) : $signed({2'b00, q_r});
  always_comb begin
    if (sq > 50'sh7FFF_FFFF) quot = 32'sh7FFF_FFFF;
    else if (sq < -50'sh8000_0000) quot = 32'sh8000_0000;
    else quot = sq[31:0];
  end
  assign done = done_r;
endmodule
